// ----- design/wndi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package wndi_pkg;
    localparam int MaxObs = 1024;
    localparam int MaxDonors = 16;
    localparam int IdxW = $clog2(MaxObs);
    localparam int CntW = $clog2(MaxObs + 1);
    localparam int DonW = $clog2(MaxDonors);
    localparam int DcntW = $clog2(MaxDonors + 1);
    localparam int DistW = 33;
    localparam int WgtW = 16;
    localparam int SumW = WgtW + DonW + 1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_QUERY = 1'b1;
    localparam logic REG_DONOR_COUNT = 1'b0;
    localparam logic REG_OBS_COUNT = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load_wr;
        logic scan_start;
        logic scan_rd;
        logic scan_ins;
        logic sum_start;
        logic sum_rd;
        logic sum_acc;
        logic draw_start;
        logic draw_rd;
        logic draw_acc;
        logic fin_rd;
        logic fin_take;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic scan_last;
        logic list_last;
        logic hit;
        logic zero_sum;
    } t_sts;
endpackage
`default_nettype wire

// ----- design/wndi_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface wndi_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [9:0]  obs_index;
    logic signed [31:0] obs_prediction;
    logic signed [31:0] obs_value;
    logic [15:0] obs_weight;
    logic signed [31:0] query_prediction;
    logic [15:0] random_draw;
    modport source (output valid, opcode, obs_index, obs_prediction, obs_value, obs_weight,
                    query_prediction, random_draw, input ready);
    modport sink (input valid, opcode, obs_index, obs_prediction, obs_value, obs_weight,
                  query_prediction, random_draw, output ready);
endinterface

interface wndi_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] imputed_value;
    logic [9:0]  donor_index;
    logic        weight_error;
    modport source (output valid, imputed_value, donor_index, weight_error, input ready);
    modport sink (input valid, imputed_value, donor_index, weight_error, output ready);
endinterface

interface wndi_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [10:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- design/wndi_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wndi_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // single write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- design/wndi_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wndi_datapath (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire wndi_pkg::t_cmd           i_cmd,
    output wndi_pkg::t_sts                o_sts,
    input  wire logic [wndi_pkg::IdxW-1:0] i_ld_index,
    input  wire logic [31:0]              i_ld_pred,
    input  wire logic [31:0]              i_ld_value,
    input  wire logic [15:0]              i_ld_weight,
    input  wire logic [31:0]              i_query,
    input  wire logic [15:0]              i_draw,
    input  wire logic [wndi_pkg::CntW-1:0]  i_n,
    input  wire logic [wndi_pkg::DcntW-1:0] i_k,
    output logic      [31:0]              o_value,
    output logic      [wndi_pkg::IdxW-1:0] o_index,
    output logic                          o_error
);
    localparam int Nd = wndi_pkg::MaxDonors;
    localparam int DcntW = wndi_pkg::DcntW;
    localparam int DonW = wndi_pkg::DonW;

    logic [wndi_pkg::IdxW-1:0] ram_raddr;
    logic [31:0] pred_q;
    logic [31:0] val_q;
    logic [wndi_pkg::WgtW-1:0] wgt_q;

    wndi_ram #(.Width(32), .Depth(wndi_pkg::MaxObs)) u_pred (
        .i_clk, .i_we(i_cmd.load_wr), .i_waddr(i_ld_index), .i_wdata(i_ld_pred),
        .i_raddr(ram_raddr), .o_rdata(pred_q));
    wndi_ram #(.Width(32), .Depth(wndi_pkg::MaxObs)) u_val (
        .i_clk, .i_we(i_cmd.load_wr), .i_waddr(i_ld_index), .i_wdata(i_ld_value),
        .i_raddr(ram_raddr), .o_rdata(val_q));
    wndi_ram #(.Width(wndi_pkg::WgtW), .Depth(wndi_pkg::MaxObs)) u_wgt (
        .i_clk, .i_we(i_cmd.load_wr), .i_waddr(i_ld_index), .i_wdata(i_ld_weight),
        .i_raddr(ram_raddr), .o_rdata(wgt_q));

    logic [wndi_pkg::CntW-1:0] r_scan, n_scan;
    logic [wndi_pkg::IdxW-1:0] r_ins_idx;
    logic [wndi_pkg::DcntW-1:0] r_len, r_j;
    logic [wndi_pkg::DistW-1:0] r_dist [Nd];
    logic [wndi_pkg::IdxW-1:0] r_nidx [Nd];
    logic [wndi_pkg::SumW-1:0] r_total, r_cum;
    logic [wndi_pkg::SumW+15:0] r_target;
    logic [wndi_pkg::IdxW-1:0] r_pick;
    logic [wndi_pkg::DonW-1:0] j_sel;

    assign j_sel = r_j[wndi_pkg::DonW-1:0];

    // read address: scan counter, picked donor or donor list entry
    always_comb begin
        if (i_cmd.scan_rd) begin
            ram_raddr = r_scan[wndi_pkg::IdxW-1:0];
        end else if (i_cmd.fin_rd) begin
            ram_raddr = r_pick;
        end else begin
            ram_raddr = r_nidx[j_sel];
        end
    end

    // distance of the entry read last cycle
    logic signed [32:0] diff;
    logic [wndi_pkg::DistW-1:0] cand_dist;
    assign diff = {i_query[31], i_query} - {pred_q[31], pred_q};
    assign cand_dist = diff[32] ? wndi_pkg::DistW'(-diff) : wndi_pkg::DistW'(diff);

    // insertion into the sorted list: per-slot compare, shift on greater
    logic [Nd-1:0] gt;
    always_comb begin
        for (int m = 0; m < Nd; m++) begin
            gt[m] = (DcntW'(m) < r_len) && (cand_dist < r_dist[m]);
        end
    end

    logic [DcntW-1:0] pos;
    always_comb begin
        pos = r_len;
        for (int m = 0; m < Nd; m++) begin
            if (gt[m] && DcntW'(m) < pos) begin
                pos = DcntW'(m);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_len <= '0;
            r_scan <= '0;
        end else begin
            r_scan <= n_scan;
            if (i_cmd.scan_ins && pos < i_k) begin
                for (int m = Nd - 1; m >= 0; m--) begin
                    if (DcntW'(m) == pos) begin
                        r_dist[m] <= cand_dist;
                        r_nidx[m] <= r_ins_idx;
                    end else if (DcntW'(m) > pos && m > 0) begin
                        r_dist[m] <= r_dist[m-1];
                        r_nidx[m] <= r_nidx[m-1];
                    end
                end
                if (r_len < i_k) begin
                    r_len <= r_len + 1'b1;
                end
            end
        end
        if (i_cmd.scan_rd) begin
            r_ins_idx <= r_scan[wndi_pkg::IdxW-1:0];
        end
        if (!i_rst_n) begin
            r_len <= '0;
        end
    end

    assign n_scan = i_cmd.scan_rd ? r_scan + 1'b1 : r_scan;

    // weight sum and cumulative draw walk
    logic [wndi_pkg::SumW-1:0] cum_next;
    assign cum_next = r_cum + wndi_pkg::SumW'(wgt_q);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_start || i_cmd.draw_start) begin
            r_j <= '0;
            r_cum <= '0;
        end else if (i_cmd.sum_rd || i_cmd.draw_rd) begin
            r_j <= r_j + 1'b1;
        end
        if (i_cmd.sum_start) begin
            r_total <= '0;
        end else if (i_cmd.sum_acc) begin
            r_total <= r_total + wndi_pkg::SumW'(wgt_q);
        end
        if (i_cmd.draw_start) begin
            r_target <= (wndi_pkg::SumW+16)'(i_draw) * (wndi_pkg::SumW+16)'(r_total);
            r_pick <= r_nidx[DonW'(r_len - 1'b1)];
        end else if (i_cmd.draw_acc) begin
            r_cum <= cum_next;
            if ({cum_next, 16'd0} > r_target) begin
                r_pick <= r_nidx[DonW'(r_j - 1'b1)];
            end
        end
        if (i_cmd.fin_take) begin
            o_value <= val_q;
            o_index <= r_pick;
            o_error <= 1'b0;
        end else if (i_cmd.sum_acc && 1'b0) begin
            o_error <= 1'b0;
        end else if (i_cmd.draw_start && r_total == '0) begin
            o_value <= '0;
            o_index <= '0;
            o_error <= 1'b1;
        end
    end

    assign o_sts.scan_last = (n_scan == i_n);
    assign o_sts.list_last = (r_j + 1'b1 == r_len);
    assign o_sts.hit = ({cum_next, 16'd0} > r_target);
    assign o_sts.zero_sum = (r_total == '0);
endmodule
`default_nettype wire

// ----- design/wndi_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wndi_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_opcode,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output wndi_pkg::t_cmd      o_cmd,
    input  wire wndi_pkg::t_sts i_sts
);
    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SCAN_TAIL, S_SUM, S_SUM_TAIL, S_DRAW_INIT,
        S_DRAW, S_DRAW_TAIL, S_FIN_RD, S_FIN, S_OUT
    } t_state;

    t_state r_state;
    logic r_hit_seen;
    logic r_rd_q;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // command decode per state, table data is used in the cycle after its read
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_wr = i_in_valid && i_in_opcode == wndi_pkg::OP_LOAD;
                o_cmd.scan_start = i_in_valid && i_in_opcode == wndi_pkg::OP_QUERY;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                o_cmd.scan_ins = r_rd_q;
            end
            S_SCAN_TAIL: begin
                o_cmd.scan_ins = 1'b1;
                o_cmd.sum_start = 1'b1;
            end
            S_SUM: begin
                o_cmd.sum_rd = 1'b1;
                o_cmd.sum_acc = r_rd_q;
            end
            S_SUM_TAIL: o_cmd.sum_acc = 1'b1;
            S_DRAW_INIT: o_cmd.draw_start = 1'b1;
            S_DRAW: begin
                o_cmd.draw_rd = 1'b1;
                o_cmd.draw_acc = r_rd_q && !r_hit_seen;
            end
            S_DRAW_TAIL: o_cmd.draw_acc = !r_hit_seen;
            S_FIN_RD: o_cmd.fin_rd = 1'b1;
            S_FIN: o_cmd.fin_take = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hit_seen <= 1'b0;
            r_rd_q <= 1'b0;
        end else begin
            r_rd_q <= o_cmd.scan_rd || o_cmd.sum_rd || o_cmd.draw_rd;
            case (r_state)
                S_IDLE: if (i_in_valid && i_in_opcode == wndi_pkg::OP_QUERY) begin
                    r_state <= S_SCAN;
                end
                S_SCAN: if (i_sts.scan_last) begin
                    r_state <= S_SCAN_TAIL;
                end
                S_SCAN_TAIL: r_state <= S_SUM;
                S_SUM: if (i_sts.list_last) begin
                    r_state <= S_SUM_TAIL;
                end
                S_SUM_TAIL: r_state <= S_DRAW_INIT;
                S_DRAW_INIT: begin
                    r_hit_seen <= 1'b0;
                    r_state <= i_sts.zero_sum ? S_OUT : S_DRAW;
                end
                S_DRAW: begin
                    if (o_cmd.draw_acc && i_sts.hit) begin
                        r_hit_seen <= 1'b1;
                    end
                    if (i_sts.list_last) begin
                        r_state <= S_DRAW_TAIL;
                    end
                end
                S_DRAW_TAIL: r_state <= S_FIN_RD;
                S_FIN_RD: r_state <= S_FIN;
                S_FIN: r_state <= S_OUT;
                S_OUT: if (i_out_ready) begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/weighted_nearest_donor_imputer_core.sv -----
// a query scans the n table entries, then walks its k nearest donors twice, for the weight
// sum and for the draw (n = effective obs_count, k = effective donor_count); a zero weight
// sum skips the draw; one table read a cycle in the scan loop and in the two donor walks
// only one query is in flight at a time; a load is a single table write taken while idle
// the result stays valid until taken; the next request is taken after that
// reset (synchronous, active low) clears control, donor_count 5, obs_count 1; tables undefined
`timescale 1ns / 1ps
`default_nettype none
module weighted_nearest_donor_imputer_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    wndi_in_if.sink   i_in,
    wndi_out_if.source o_out,
    wndi_cfg_if.sink  i_cfg
);
    wndi_pkg::t_cmd cmd;
    wndi_pkg::t_sts sts;
    logic [4:0] r_donor_count;
    logic [10:0] r_obs_count;
    logic [wndi_pkg::CntW-1:0] n_eff;
    logic [wndi_pkg::DcntW-1:0] k_eff;
    logic [31:0] r_query;
    logic [15:0] r_draw;

    // configuration registers
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_donor_count <= 5'd5;
            r_obs_count <= 11'd1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                wndi_pkg::REG_DONOR_COUNT: r_donor_count <= i_cfg.data[4:0];
                wndi_pkg::REG_OBS_COUNT: r_obs_count <= i_cfg.data;
                default: r_obs_count <= r_obs_count;
            endcase
        end
    end

    // effective counts with clamping
    always_comb begin
        logic [10:0] kk;
        if (r_obs_count == '0) begin
            n_eff = wndi_pkg::CntW'(1);
        end else if (r_obs_count > 11'(wndi_pkg::MaxObs)) begin
            n_eff = wndi_pkg::CntW'(wndi_pkg::MaxObs);
        end else begin
            n_eff = wndi_pkg::CntW'(r_obs_count);
        end
        kk = 11'(r_donor_count);
        if (kk == '0) kk = 11'd1;
        if (kk > 11'(wndi_pkg::MaxDonors)) kk = 11'(wndi_pkg::MaxDonors);
        if (kk > 11'(n_eff)) kk = 11'(n_eff);
        k_eff = wndi_pkg::DcntW'(kk);
    end

    // query fields held for the whole search
    always_ff @(posedge i_clk) begin
        if (cmd.scan_start) begin
            r_query <= i_in.query_prediction;
            r_draw <= i_in.random_draw;
        end
    end

    wndi_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(i_in.valid), .i_in_opcode(i_in.opcode), .o_in_ready(i_in.ready),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .o_cmd(cmd), .i_sts(sts));

    wndi_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts),
        .i_ld_index(i_in.obs_index), .i_ld_pred(i_in.obs_prediction),
        .i_ld_value(i_in.obs_value), .i_ld_weight(i_in.obs_weight),
        .i_query(r_query), .i_draw(r_draw), .i_n(n_eff), .i_k(k_eff),
        .o_value(o_out.imputed_value), .o_index(o_out.donor_index),
        .o_error(o_out.weight_error));
endmodule
`default_nettype wire

// ----- design/wndi_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wndi_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic in_opcode,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic out_error,
    input wire logic [9:0] out_index
);
    // no new request while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("request taken during result");
    // result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_index))
        else $error("result dropped");
    // error result carries index zero
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_error |-> out_index == 10'd0) else $error("error index");
    // a load never yields a result next cycle
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && !in_opcode |=> !out_valid) else $error("load result");
endmodule

bind weighted_nearest_donor_imputer_core wndi_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(i_in.valid), .in_ready(i_in.ready),
    .in_opcode(i_in.opcode), .out_valid(o_out.valid), .out_ready(o_out.ready),
    .out_error(o_out.weight_error), .out_index(o_out.donor_index));
`default_nettype wire

// ----- tb/sv/weighted_nearest_donor_imputer_core_tb.sv -----
`timescale 1ns / 1ps
module weighted_nearest_donor_imputer_core_tb;
    localparam int WatchdogLimit = 8000;
    localparam int HoldOffCycles = 2500;

    typedef struct {
        logic               op;
        logic [9:0]         idx;
        logic signed [31:0] pred;
        logic signed [31:0] val;
        logic [15:0]        wgt;
        logic signed [31:0] q;
        logic [15:0]        u;
    } t_req;

    typedef struct {
        logic signed [31:0] value;
        logic [9:0]         donor;
        logic               werr;
    } t_imputation;

    logic i_clk;
    logic i_rst_n;

    wndi_in_if  in_if();
    wndi_out_if out_if();
    wndi_cfg_if cfg_if();

    weighted_nearest_donor_imputer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // local copy of the observation tables and registers
    logic signed [31:0] pred_mem [wndi_pkg::MaxObs];
    logic signed [31:0] value_mem [wndi_pkg::MaxObs];
    logic [15:0]        weight_mem [wndi_pkg::MaxObs];
    bit                 loaded [wndi_pkg::MaxObs];
    int unsigned        donor_cfg;
    int unsigned        obs_cfg;

    t_imputation pending_imputations[$];
    int          mismatches;
    int          burst_left;
    int          hold_cycles;
    int          quiet_cycles;

    // clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic int unsigned eff_obs();
        if (obs_cfg == 0) return 1;
        if (obs_cfg > wndi_pkg::MaxObs) return wndi_pkg::MaxObs;
        return obs_cfg;
    endfunction

    function automatic int unsigned loaded_prefix();
        int unsigned p;
        p = 0;
        while (p < wndi_pkg::MaxObs && loaded[p]) p++;
        return p;
    endfunction

    // nearest donors by distance then index, weighted draw by cumulative sum
    function automatic t_imputation impute(logic signed [31:0] q, logic [15:0] u);
        t_imputation     r;
        int unsigned     n;
        int unsigned     k;
        int unsigned     len;
        int unsigned     pos;
        int unsigned     last;
        int unsigned     pick;
        longint          diff;
        longint unsigned d;
        longint unsigned total;
        longint unsigned cum;
        longint unsigned target;
        longint unsigned near_dist [wndi_pkg::MaxDonors];
        int unsigned     didx [wndi_pkg::MaxDonors];
        n = eff_obs();
        k = (donor_cfg == 0) ? 1 : donor_cfg;
        if (k > wndi_pkg::MaxDonors) k = wndi_pkg::MaxDonors;
        if (k > n) k = n;
        len = 0;
        for (int unsigned i = 0; i < n; i++) begin
            diff = longint'(q) - longint'(pred_mem[i]);
            d = (diff < 0) ? longint'(-diff) : diff;
            pos = len;
            while (pos > 0 && d < near_dist[pos-1]) pos--;
            if (pos < k) begin
                last = (len < k) ? len : k - 1;
                for (int unsigned m = last; m > pos; m--) begin
                    near_dist[m] = near_dist[m-1];
                    didx[m] = didx[m-1];
                end
                near_dist[pos] = d;
                didx[pos] = i;
                if (len < k) len++;
            end
        end
        total = 0;
        for (int unsigned j = 0; j < len; j++) total += weight_mem[didx[j]];
        if (total == 0) begin
            r.value = '0;
            r.donor = '0;
            r.werr  = 1'b1;
            return r;
        end
        target = longint'(u) * total;
        cum = 0;
        pick = didx[len-1];
        for (int unsigned j = 0; j < len; j++) begin
            cum += weight_mem[didx[j]];
            if (cum * 65536 > target) begin
                pick = didx[j];
                break;
            end
        end
        r.value = value_mem[pick];
        r.donor = pick[9:0];
        r.werr  = 1'b0;
        return r;
    endfunction

    function automatic t_req random_req();
        t_req r;
        r.op   = 1'($urandom);
        r.idx  = 10'($urandom);
        r.pred = $urandom;
        r.val  = $urandom;
        r.wgt  = 16'($urandom);
        r.q    = $urandom;
        r.u    = 16'($urandom);
        return r;
    endfunction

    // send one request in bursts with random gaps, update the local tables or queue the expected result
    task automatic send_req(t_req r);
        bit fire;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_if.valid            <= 1'b1;
        in_if.opcode           <= r.op;
        in_if.obs_index        <= r.idx;
        in_if.obs_prediction   <= r.pred;
        in_if.obs_value        <= r.val;
        in_if.obs_weight       <= r.wgt;
        in_if.query_prediction <= r.q;
        in_if.random_draw      <= r.u;
        do begin
            @(negedge i_clk);
            fire = in_if.ready;
            @(posedge i_clk);
        end while (!fire);
        if (r.op == wndi_pkg::OP_LOAD) begin
            pred_mem[r.idx]   = r.pred;
            value_mem[r.idx]  = r.val;
            weight_mem[r.idx] = r.wgt;
            loaded[r.idx]     = 1'b1;
        end else begin
            pending_imputations.insert(pending_imputations.size(), impute(r.q, r.u));
        end
    endtask

    task automatic load_obs(int unsigned idx, logic signed [31:0] p, logic signed [31:0] v,
                            logic [15:0] w);
        t_req r;
        r = random_req();
        r.op = wndi_pkg::OP_LOAD;
        r.idx = idx[9:0];
        r.pred = p;
        r.val = v;
        r.wgt = w;
        send_req(r);
    endtask

    task automatic query(logic signed [31:0] q, logic [15:0] u);
        t_req r;
        r = random_req();
        r.op = wndi_pkg::OP_QUERY;
        r.q = q;
        r.u = u;
        send_req(r);
    endtask

    // drop valid, drain all results, then let the block finish its last request
    task automatic settle();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_imputations.size() != 0) @(posedge i_clk);
        repeat (eff_obs() + 2 * wndi_pkg::MaxDonors + 16) @(posedge i_clk);
    endtask

    task automatic write_reg(logic index, int unsigned data);
        bit fire;
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= data[10:0];
        do begin
            @(negedge i_clk);
            fire = cfg_if.ready;
            @(posedge i_clk);
        end while (!fire);
        cfg_if.valid <= 1'b0;
        if (index == wndi_pkg::REG_DONOR_COUNT) donor_cfg = data & 'h1F;
        else obs_cfg = data & 'h7FF;
    endtask

    task automatic configure(int unsigned donors, int unsigned obs);
        settle();
        write_reg(wndi_pkg::REG_DONOR_COUNT, donors);
        write_reg(wndi_pkg::REG_OBS_COUNT, obs);
    endtask

    // load whatever entries the next queries will read
    task automatic fill_prefix();
        int unsigned p;
        p = loaded_prefix();
        while (p < eff_obs()) begin
            load_obs(p, $urandom, $urandom, 16'($urandom));
            p = loaded_prefix();
        end
    endtask

    // extremes, ties, zero weight sum and out-of-range register values
    task automatic test_directed();
        load_obs(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF);
        load_obs(1, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'h0001);
        load_obs(2, 32'sh0001_0000, 32'sh0000_1234, 16'h0010);
        load_obs(3, 32'sh0010_0000, 32'sh0000_0003, 16'h0000);
        load_obs(4, 32'sh0001_0000, 32'sh0000_0004, 16'h0020);
        load_obs(5, 32'sh0000_0000, 32'shFFFF_FFFF, 16'h8000);
        query(32'sh8000_0000, 16'h0000);
        configure(16, 6);
        query(32'sh0001_0000, 16'h0000);
        query(32'sh0001_0000, 16'hFFFF);
        query(32'sh7FFF_FFFF, 16'h8000);
        query(32'sh8000_0000, 16'hFFFF);
        configure(1, 6);
        query(32'sh0010_0000, 16'h1234);
        configure(0, 0);
        query(32'sh7FFF_FFFF, 16'hFFFF);
        configure(31, 6);
        query(32'sh0000_8000, 16'h7FFF);
        configure(2, 6);
        query(32'sh0010_0001, 16'h0001);
    endtask

    // random phases over fixed and random settings, queries only over loaded entries
    task automatic test_random();
        t_req r;
        int unsigned donors;
        int unsigned obs;
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin donors = 16; obs = 16; end
                1: begin donors = 0;  obs = 1;  end
                2: begin donors = 31; obs = 40; end
                3: begin donors = 1;  obs = 0;  end
                default: begin
                    donors = $urandom_range(0, 31);
                    obs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                      : $urandom_range(4, 48);
                end
            endcase
            configure(donors, obs);
            fill_prefix();
            for (int i = 0; i < 50; i++) begin
                r = random_req();
                if ($urandom_range(0, 9) < 6) begin
                    r.op = wndi_pkg::OP_QUERY;
                    // aim near a stored prediction to provoke ties
                    if ($urandom_range(0, 1) == 1)
                        r.q = pred_mem[$urandom_range(0, eff_obs() - 1)]
                              + 32'($urandom_range(0, 2)) - 1;
                end else begin
                    r.op = wndi_pkg::OP_LOAD;
                    r.idx = 10'($urandom_range(0, 63));
                    if ($urandom_range(0, 3) == 0) r.pred = 32'($urandom_range(0, 3)) << 16;
                    if ($urandom_range(0, 4) == 0) r.wgt = '0;
                end
                send_req(r);
            end
        end
    endtask

    // receiver holds off while the sender keeps offering requests
    task automatic test_backpressure();
        t_req r;
        configure(5, 12);
        fill_prefix();
        hold_cycles = HoldOffCycles;
        for (int i = 0; i < 12; i++) begin
            r = random_req();
            if (i % 3 == 2) r.idx = 10'($urandom_range(0, 11));
            send_req(r);
        end
    endtask

    // receiver stall pattern; mode and pattern are redrawn from a free-running cycle counter
    logic [15:0] stall_pat;
    int unsigned stall_mode;
    int unsigned rx_cycle;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_cycle <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 128 == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_pat = 16'($urandom);
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_if.ready <= 1'b0;
            end else if (stall_mode == 0) begin
                out_if.ready <= 1'b1;
            end else if (stall_mode == 1) begin
                out_if.ready <= stall_pat[rx_cycle % 16];
            end else begin
                out_if.ready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // result check and watchdog, sampled mid-cycle
    always @(negedge i_clk) begin
        t_imputation want;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (pending_imputations.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result value=%h donor=%0d err=%b",
                                 out_if.imputed_value, out_if.donor_index,
                                 out_if.weight_error);
                end else begin
                    want = pending_imputations.pop_front();
                    if (out_if.imputed_value !== want.value
                        || out_if.donor_index !== want.donor
                        || out_if.weight_error !== want.werr) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp %h/%0d/%b got %h/%0d/%b",
                                     want.value, want.donor, want.werr,
                                     out_if.imputed_value, out_if.donor_index,
                                     out_if.weight_error);
                    end
                end
            end
            if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WatchdogLimit) begin
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    initial begin
        i_rst_n                <= 1'b0;
        in_if.valid            <= 1'b0;
        in_if.opcode           <= wndi_pkg::OP_LOAD;
        in_if.obs_index        <= '0;
        in_if.obs_prediction   <= '0;
        in_if.obs_value        <= '0;
        in_if.obs_weight       <= '0;
        in_if.query_prediction <= '0;
        in_if.random_draw      <= '0;
        cfg_if.valid           <= 1'b0;
        cfg_if.index           <= wndi_pkg::REG_DONOR_COUNT;
        cfg_if.data            <= '0;
        donor_cfg = 5;
        obs_cfg = 1;
        mismatches = 0;
        burst_left = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        stall_mode = 0;
        stall_pat = '1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random();
        test_backpressure();
        settle();

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ----- files.f -----
design/wndi_pkg.sv
design/wndi_if.sv
design/wndi_ram.sv
design/wndi_datapath.sv
design/wndi_ctrl.sv
design/weighted_nearest_donor_imputer_core.sv
design/wndi_checker.sv
tb/sv/weighted_nearest_donor_imputer_core_tb.sv
